// File: hdl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Types and constants shared by the stack machine execute unit and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package smeu_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam int CACHE_N     = 8;
   localparam int CACHE_W     = $clog2(CACHE_N + 1);
   localparam int POP_REACH   = 4;

   localparam int WORD_W      = 64;
   localparam int HALF_W      = WORD_W / 2;
   localparam int FUNC_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int TARGET_W    = 16;
   localparam int DEPTH_W     = 9;
   localparam int POP_W       = 2;

   localparam int REQ_FIELDS_W = FUNC_W + WORD_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 1 + TARGET_W + WORD_W + DEPTH_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_PROGRAM_LENGTH = 1'b0;

   localparam logic [1:0] MUL_LAST_STEP = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH = 4'd0,
      FN_ADD  = 4'd1,
      FN_SUB  = 4'd2,
      FN_MUL  = 4'd3,
      FN_POP  = 4'd4,
      FN_JMP  = 4'd5,
      FN_CMP  = 4'd6,
      FN_JLT  = 4'd7,
      FN_JGT  = 4'd8,
      FN_JEQ  = 4'd9,
      FN_JNQ  = 4'd10,
      FN_DUP  = 4'd11,
      FN_NOP  = 4'd12
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_PAST  = 3'd3,
      ST_ZERO  = 3'd4
   } status_type;

   typedef struct packed {
      logic start;
      logic take;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

`default_nettype wire

// File: hdl/stack_machine_execute_unit.sv
// A request is held in the input register until it executes; its result is then registered.
// Throughput: one instruction per cycle while the cache holds 4+ words and rsp_tready is high.
// A deep pop that drains the cache stalls while words reload from the RAM, up to two at a time.
// mul holds the unit while the 32x32 multiplier steps through its partial products.
// Reset empties the stack and sets program_length to zero; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one instruction of a 64-bit stack machine per transaction, with the
// top of the stack held in registers and the rest in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: func[3:0], arg[67:4], zero padding
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [smeu_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: status[2:0], jump_taken[3], jump_target[19:4], top_value[83:20],
   // depth[92:84], zero padding
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [smeu_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [smeu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [smeu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [smeu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);

   localparam int W  = smeu_pkg::WORD_W;
   localparam int CN = smeu_pkg::CACHE_N;

   logic                              in_valid_ff;
   logic [smeu_pkg::FUNC_W-1:0]       in_func_ff;
   logic [W-1:0]                      in_arg_ff;
   logic [smeu_pkg::TARGET_W-1:0]     prog_len_ff;
   logic [smeu_pkg::CNT_W-1:0]        count_ff;
   logic [smeu_pkg::CACHE_W-1:0]      cache_n_ff;
   logic [W-1:0]                      cache_ff [CN];
   logic                              refill_pend_ff;
   logic                              refill_two_ff;
   logic                              rsp_valid_ff;
   smeu_pkg::status_type              status_ff;
   logic                              taken_ff;
   logic [smeu_pkg::TARGET_W-1:0]     target_ff;
   logic [W-1:0]                      top_ff;
   logic [smeu_pkg::DEPTH_W-1:0]      depth_ff;

   smeu_pkg::func_type                func;
   logic [smeu_pkg::CNT_W-1:0]        mem_n;
   logic                              cnt_ge1;
   logic                              cnt_ge2;
   logic                              cnt_ge3;
   logic                              full;
   logic                              cond;
   logic                              jump_ok;
   smeu_pkg::status_type              jump_status;
   logic [W-1:0]                      cmp_word;
   logic [smeu_pkg::POP_W-1:0]        pop_n;
   logic                              push;
   logic [W-1:0]                      push_word;
   smeu_pkg::status_type              status_in;
   logic                              taken_in;
   logic                              mul_need;
   logic [W-1:0]                      cache_ext [CN+3];
   logic [W-1:0]                      sh [CN];
   logic [W-1:0]                      cache_in [CN];
   logic [smeu_pkg::CACHE_W-1:0]      cache_n_sh;
   logic [smeu_pkg::CACHE_W-1:0]      cache_n_in;
   logic [smeu_pkg::CNT_W-1:0]        count_in;
   logic                              spill;
   logic [W-1:0]                      top_in;
   logic                              cache_ok;
   logic                              out_free;
   logic                              exec;
   logic                              refill_go;
   logic                              refill_two;
   logic [W-1:0]                      rd_a;
   logic [W-1:0]                      rd_b;
   logic [W-1:0]                      product;
   smeu_pkg::mul_ctl_type             mul_ctl;
   smeu_pkg::mul_sts_type             mul_sts;
   logic                              csr_wr;

   assign func    = smeu_pkg::func_type'(in_func_ff);
   assign mem_n   = count_ff - smeu_pkg::CNT_W'(cache_n_ff);
   assign cnt_ge1 = count_ff != '0;
   assign cnt_ge2 = count_ff >= smeu_pkg::CNT_W'(2);
   assign cnt_ge3 = count_ff >= smeu_pkg::CNT_W'(3);
   assign full    = count_ff >= smeu_pkg::CNT_W'(smeu_pkg::STACK_DEPTH);

   always_comb begin
      case (func) inside
         smeu_pkg::FN_JLT: cond = cache_ff[0] == {W{1'b1}};
         smeu_pkg::FN_JGT: cond = cache_ff[0] == W'(1);
         smeu_pkg::FN_JEQ: cond = cache_ff[0] == '0;
         default:          cond = cache_ff[0] != '0;
      endcase
   end

   always_comb begin
      jump_ok = 1'b0;
      if (in_arg_ff > W'(prog_len_ff)) begin
         jump_status = smeu_pkg::ST_PAST;
      end else if (in_arg_ff == '0) begin
         jump_status = smeu_pkg::ST_ZERO;
      end else begin
         jump_status = smeu_pkg::ST_OK;
         jump_ok     = 1'b1;
      end
   end

   assign cmp_word = ($signed(cache_ff[1]) > $signed(cache_ff[0])) ? W'(1) :
                     (cache_ff[1] == cache_ff[0]) ? '0 : {W{1'b1}};

   always_comb begin
      pop_n     = '0;
      push      = 1'b0;
      push_word = in_arg_ff;
      status_in = smeu_pkg::ST_OK;
      taken_in  = 1'b0;
      mul_need  = 1'b0;
      unique case (func) inside
         smeu_pkg::FN_PUSH: begin
            if (full) status_in = smeu_pkg::ST_OVER;
            else push = 1'b1;
         end
         smeu_pkg::FN_ADD, smeu_pkg::FN_SUB, smeu_pkg::FN_MUL: begin
            if (!cnt_ge1) begin
               status_in = smeu_pkg::ST_UNDER;
            end else if (!cnt_ge2) begin
               pop_n     = 2'd1;
               status_in = smeu_pkg::ST_UNDER;
            end else begin
               pop_n = 2'd2;
               push  = 1'b1;
               if (func == smeu_pkg::FN_ADD) begin
                  push_word = cache_ff[0] + cache_ff[1];
               end else if (func == smeu_pkg::FN_SUB) begin
                  push_word = cache_ff[0] - cache_ff[1];
               end else begin
                  push_word = product;
                  mul_need  = 1'b1;
               end
            end
         end
         smeu_pkg::FN_POP: begin
            if (!cnt_ge1) status_in = smeu_pkg::ST_UNDER;
            else pop_n = 2'd1;
         end
         smeu_pkg::FN_JMP: begin
            status_in = jump_status;
            taken_in  = jump_ok;
         end
         smeu_pkg::FN_CMP: begin
            if (!cnt_ge2) begin
               status_in = smeu_pkg::ST_UNDER;
            end else if (full) begin
               status_in = smeu_pkg::ST_OVER;
            end else begin
               push      = 1'b1;
               push_word = cmp_word;
            end
         end
         smeu_pkg::FN_JLT, smeu_pkg::FN_JGT, smeu_pkg::FN_JEQ, smeu_pkg::FN_JNQ: begin
            if (!cnt_ge1) begin
               status_in = smeu_pkg::ST_UNDER;
            end else begin
               pop_n = cnt_ge3 ? 2'd3 : (cnt_ge2 ? 2'd2 : 2'd1);
               if (cond) begin
                  status_in = jump_status;
                  taken_in  = jump_ok;
               end else if (!cnt_ge3) begin
                  status_in = smeu_pkg::ST_UNDER;
               end
            end
         end
         smeu_pkg::FN_DUP: begin
            if (!cnt_ge1) begin
               status_in = smeu_pkg::ST_UNDER;
            end else if (full) begin
               status_in = smeu_pkg::ST_OVER;
            end else begin
               push      = 1'b1;
               push_word = cache_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CN + 3; i++) begin
         cache_ext[i] = (i < CN) ? cache_ff[i % CN] : '0;
      end
      for (int i = 0; i < CN; i++) begin
         case (pop_n)
            2'd0:    sh[i] = cache_ext[i];
            2'd1:    sh[i] = cache_ext[i + 1];
            2'd2:    sh[i] = cache_ext[i + 2];
            default: sh[i] = cache_ext[i + 3];
         endcase
      end
      cache_n_sh = cache_n_ff - smeu_pkg::CACHE_W'(pop_n);
      cache_in[0] = push ? push_word : sh[0];
      for (int i = 1; i < CN; i++) begin
         cache_in[i] = push ? sh[i - 1] : sh[i];
      end
      spill = push && (cache_n_sh == smeu_pkg::CACHE_W'(CN));
      if (!push) begin
         cache_n_in = cache_n_sh;
      end else if (spill) begin
         cache_n_in = cache_n_sh;
      end else begin
         cache_n_in = cache_n_sh + smeu_pkg::CACHE_W'(1);
      end
      count_in = count_ff - smeu_pkg::CNT_W'(pop_n) + smeu_pkg::CNT_W'(push);
      top_in   = (count_in != '0) ? cache_in[0] : '0;
   end

   assign cache_ok  = (smeu_pkg::CNT_W'(cache_n_ff) >= count_ff) ||
                      (cache_n_ff >= smeu_pkg::CACHE_W'(smeu_pkg::POP_REACH));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign exec      = in_valid_ff && cache_ok && out_free && !refill_pend_ff &&
                      (!mul_need || mul_sts.done);
   assign req_tready = !in_valid_ff || exec;

   assign mul_ctl.start = in_valid_ff && mul_need && cache_ok && !mul_sts.busy &&
                          !mul_sts.done;
   assign mul_ctl.take  = exec;

   assign refill_go  = !exec && !refill_pend_ff && (mem_n != '0) &&
                       (cache_n_ff < smeu_pkg::CACHE_W'(CN));
   assign refill_two = (mem_n >= smeu_pkg::CNT_W'(2)) &&
                       (cache_n_ff <= smeu_pkg::CACHE_W'(CN - 2));

   smeu_ram #(
      .WIDTH (W),
      .DEPTH (smeu_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock     (clock),
      .wr_en     (exec && spill),
      .wr_addr   (smeu_pkg::ADDR_W'(mem_n)),
      .wr_data   (cache_ff[CN - 1]),
      .rd_addr_a (smeu_pkg::ADDR_W'(mem_n - smeu_pkg::CNT_W'(1))),
      .rd_data_a (rd_a),
      .rd_addr_b (smeu_pkg::ADDR_W'(mem_n - smeu_pkg::CNT_W'(2))),
      .rd_data_b (rd_b)
   );

   smeu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (cache_ff[0]),
      .op_b    (cache_ff[1]),
      .sts     (mul_sts),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         count_ff       <= '0;
         cache_n_ff     <= '0;
         refill_pend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) in_valid_ff <= 1'b1;
         else if (exec) in_valid_ff <= 1'b0;

         refill_pend_ff <= refill_go;
         if (exec) begin
            count_ff   <= count_in;
            cache_n_ff <= cache_n_in;
         end else if (refill_pend_ff) begin
            cache_n_ff <= cache_n_ff + (refill_two_ff ? smeu_pkg::CACHE_W'(2) :
                                                        smeu_pkg::CACHE_W'(1));
         end

         if (exec) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tdata[smeu_pkg::FUNC_W-1:0];
         in_arg_ff  <= req_tdata[smeu_pkg::REQ_FIELDS_W-1:smeu_pkg::FUNC_W];
      end
      if (refill_go) refill_two_ff <= refill_two;
      if (exec) begin
         status_ff <= status_in;
         taken_ff  <= taken_in;
         target_ff <= taken_in ? in_arg_ff[smeu_pkg::TARGET_W-1:0] : '0;
         top_ff    <= top_in;
         depth_ff  <= smeu_pkg::DEPTH_W'(count_in);
      end
      for (int i = 0; i < CN; i++) begin
         if (exec) begin
            cache_ff[i] <= cache_in[i];
         end else if (refill_pend_ff) begin
            if (smeu_pkg::CACHE_W'(i) == cache_n_ff) begin
               cache_ff[i] <= rd_a;
            end
            if (refill_two_ff && smeu_pkg::CACHE_W'(i) == cache_n_ff + smeu_pkg::CACHE_W'(1)) begin
               cache_ff[i] <= rd_b;
            end
         end
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == smeu_pkg::CSR_IDX_PROGRAM_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff <= '0;
      end else if (csr_wr) begin
         prog_len_ff <= csr_pwdata[smeu_pkg::TARGET_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == smeu_pkg::CSR_IDX_PROGRAM_LENGTH) ?
                       smeu_pkg::CSR_DATA_W'(prog_len_ff) : '0;
   assign csr_pready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(smeu_pkg::RSP_TDATA_W - smeu_pkg::RSP_FIELDS_W){1'b0}},
                        depth_ff, top_ff, target_ff, taken_ff, status_ff};

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smeu_pkg::CNT_W'(smeu_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_cache_within_stack: assert property (@(posedge clock) disable iff (reset)
      smeu_pkg::CNT_W'(cache_n_ff) <= count_ff)
      else $error("register cache holds more words than the stack");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed instruction left no result");

   a_mul_done_owner: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (in_valid_ff && func == smeu_pkg::FN_MUL))
      else $error("product ready without a pending mul");

endmodule

`default_nettype wire

// File: hdl/smeu_ram.sv
// ----------------------------------------------------------------------------
// smeu_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// File: hdl/smeu_mul.sv
// ----------------------------------------------------------------------------
// smeu_mul
// Wrapping 64-bit multiplier built from one 32x32 multiplier over three steps.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire smeu_pkg::mul_ctl_type         ctl,
   input  wire logic [smeu_pkg::WORD_W-1:0]   op_a,
   input  wire logic [smeu_pkg::WORD_W-1:0]   op_b,
   output      smeu_pkg::mul_sts_type         sts,
   output      logic [smeu_pkg::WORD_W-1:0]   product
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [1:0]                    step_ff;
   logic [smeu_pkg::WORD_W-1:0]   a_ff;
   logic [smeu_pkg::WORD_W-1:0]   b_ff;
   logic [smeu_pkg::WORD_W-1:0]   acc_ff;
   logic [smeu_pkg::HALF_W-1:0]   mx;
   logic [smeu_pkg::HALF_W-1:0]   my;
   logic [smeu_pkg::WORD_W-1:0]   part;

   always_comb begin
      case (step_ff)
         2'd0: begin
            mx = a_ff[smeu_pkg::HALF_W-1:0];
            my = b_ff[smeu_pkg::HALF_W-1:0];
         end
         2'd1: begin
            mx = a_ff[smeu_pkg::WORD_W-1:smeu_pkg::HALF_W];
            my = b_ff[smeu_pkg::HALF_W-1:0];
         end
         default: begin
            mx = a_ff[smeu_pkg::HALF_W-1:0];
            my = b_ff[smeu_pkg::WORD_W-1:smeu_pkg::HALF_W];
         end
      endcase
      part = smeu_pkg::WORD_W'(mx) * smeu_pkg::WORD_W'(my);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         if (busy_ff && step_ff == smeu_pkg::MUL_LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else if (ctl.take) begin
            done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff    <= op_a;
         b_ff    <= op_b;
         step_ff <= 2'd0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 2'd1;
         if (step_ff == 2'd0) begin
            acc_ff <= part;
         end else begin
            acc_ff <= acc_ff + {part[smeu_pkg::HALF_W-1:0], {smeu_pkg::HALF_W{1'b0}}};
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule

`default_nettype wire
